// File: rtl/core/tcc_pkg.sv
// ----------------------------------------------------------------------------
// tcc_pkg
// Widths, types and constants shared by the triangle circumcenter pipeline.
// ----------------------------------------------------------------------------
package tcc_pkg;

  localparam int COORD_WIDTH = 20;
  localparam int FRAC_BITS   = 8;
  localparam int OUT_W       = 48;

  localparam int DIFF_W  = COORD_WIDTH + 1;
  localparam int SQ_W    = 2 * DIFF_W;
  localparam int LEN_W   = SQ_W + 1;
  localparam int CROSS_W = SQ_W + 1;
  localparam int DEN_W   = 2 * CROSS_W + 1;
  localparam int T_W     = LEN_W + DIFF_W + 1;
  localparam int NUM_W   = T_W + CROSS_W + 1;

  localparam int MUL_A_W   = T_W;
  localparam int MUL_B_W   = CROSS_W;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int MUL_K     = 22;
  localparam int MUL_NA    = (MUL_A_W + MUL_K - 1) / MUL_K;
  localparam int MUL_NB    = (MUL_B_W + MUL_K - 1) / MUL_K;
  localparam int MUL_MAG_W = (MUL_NA + MUL_NB) * MUL_K;
  localparam int MUL_LAT   = 5;

  localparam int FRONT_LAT = 3;
  localparam int QUO_W     = OUT_W;
  localparam int NUMER_W   = NUM_W + FRAC_BITS + 1;
  localparam int DIVR_W    = DEN_W + 1;
  localparam int DIV_LAT   = QUO_W + 4;
  localparam int PIPE_LAT  = 1 + FRONT_LAT + MUL_LAT + 1 + MUL_LAT + 1 + DIV_LAT;

  localparam int IN_DATA_W  = ((9 * COORD_WIDTH + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((3 * OUT_W + 7) / 8) * 8;

  localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W - 1){1'b1}}};
  localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W - 1){1'b0}}};

  typedef logic signed [COORD_WIDTH-1:0] crd_t;
  typedef logic signed [DIFF_W-1:0]      diff_t;
  typedef logic signed [SQ_W-1:0]        sq_t;
  typedef logic signed [LEN_W-1:0]       len_t;
  typedef logic signed [CROSS_W-1:0]     cross_t;
  typedef logic [DEN_W-1:0]              den_t;
  typedef logic signed [T_W-1:0]         tv_t;
  typedef logic signed [NUM_W-1:0]       num_t;
  typedef logic signed [MUL_A_W-1:0]     mula_t;
  typedef logic signed [MUL_B_W-1:0]     mulb_t;
  typedef logic signed [MUL_P_W-1:0]     mulp_t;
  typedef logic [OUT_W-1:0]              out_t;

  typedef struct packed {
    logic neg;
    logic deg;
    crd_t base;
  } div_side_t;

endpackage

// File: rtl/core/triangle_circumcenter_3d.sv
// ----------------------------------------------------------------------------
// triangle_circumcenter_3d
// Circumcenter of a 3D triangle in fixed point, fully pipelined.
// ----------------------------------------------------------------------------
// Each request on the slave stream carries the three vertices a, b and c as
// signed integer coordinates. Each result on the master stream carries the
// circumcenter with FRAC_BITS fraction bits, saturated to 48 bits, and a
// degenerate flag in tuser; a collinear triangle returns vertex a instead.
// The pipeline has one input stage, three front stages, two five-stage
// multiplier banks with a sum stage after each, and a divider of one
// quotient bit per stage for 48 bits. One request is accepted in every
// cycle while the receiver does not stall; the bit-serial divider stages
// and the split multipliers set the depth, not the rate.
// Reset clears only the valid bits of the pipeline. When the receiver
// stalls, the whole pipeline holds, and s_axis_tready drops only while a
// result waits at the output, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
module triangle_circumcenter_3d import tcc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // Fields from bit 0: ax, ay, az, bx, by_coord, bz, cx, cy, cz.
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // Fields from bit 0: center_x, center_y, center_z.
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // Fields from bit 0: degenerate.
  output logic                  m_axis_tuser
);

  logic                en;
  logic [PIPE_LAT-1:0] vld_q;

  crd_t   a0_q [3], b0_q [3], c0_q [3];
  crd_t   a_f [3];
  diff_t  ba_f [3], ca_f [3];
  len_t   bal_f, cal_f;
  cross_t cross_f [3];

  mulp_t  pden [3], ptb [3], ptc [3], pn1 [3], pn2 [3];

  cross_t cross_dq [MUL_LAT][3];
  crd_t   a_dq     [MUL_LAT][3];
  den_t   den_d;
  den_t   den_s_q;
  logic   deg_s_q;
  tv_t    t_q [3];
  cross_t cross_s_q [3];
  crd_t   a_s_q [3];

  den_t   den_dq [MUL_LAT];
  logic   deg_dq [MUL_LAT];
  crd_t   a2_dq  [MUL_LAT][3];
  num_t   num_q [3];
  den_t   den2_q;
  logic   deg2_q;
  crd_t   a2_q [3];
  logic   deg_oq [DIV_LAT];
  out_t   center [3];

  assign en            = !vld_q[PIPE_LAT-1] || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_LAT-2:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        a0_q[k] <= s_axis_tdata[k*COORD_WIDTH +: COORD_WIDTH];
        b0_q[k] <= s_axis_tdata[(k+3)*COORD_WIDTH +: COORD_WIDTH];
        c0_q[k] <= s_axis_tdata[(k+6)*COORD_WIDTH +: COORD_WIDTH];
      end
    end
  end

  tcc_front u_front (
    .clk_i   (clk_i),
    .en_i    (en),
    .a_i     (a0_q),
    .b_i     (b0_q),
    .c_i     (c0_q),
    .a_o     (a_f),
    .ba_o    (ba_f),
    .ca_o    (ca_f),
    .bal_o   (bal_f),
    .cal_o   (cal_f),
    .cross_o (cross_f)
  );

  for (genvar k = 0; k < 3; k++) begin : g_axis
    localparam int K1 = (k + 1) % 3;
    localparam int K2 = (k + 2) % 3;

    tcc_mul u_mul_den (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (MUL_A_W'(cross_f[k])),
      .b_i   (MUL_B_W'(cross_f[k])),
      .p_o   (pden[k])
    );

    tcc_mul u_mul_tb (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (MUL_A_W'(bal_f)),
      .b_i   (MUL_B_W'(ca_f[k])),
      .p_o   (ptb[k])
    );

    tcc_mul u_mul_tc (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (MUL_A_W'(cal_f)),
      .b_i   (MUL_B_W'(ba_f[k])),
      .p_o   (ptc[k])
    );

    tcc_mul u_mul_n1 (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (MUL_A_W'(t_q[K1])),
      .b_i   (MUL_B_W'(cross_s_q[K2])),
      .p_o   (pn1[k])
    );

    tcc_mul u_mul_n2 (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (MUL_A_W'(t_q[K2])),
      .b_i   (MUL_B_W'(cross_s_q[K1])),
      .p_o   (pn2[k])
    );

    tcc_div u_div (
      .clk_i    (clk_i),
      .en_i     (en),
      .num_i    (num_q[k]),
      .den_i    (den2_q),
      .base_i   (a2_q[k]),
      .deg_i    (deg2_q),
      .center_o (center[k])
    );
  end

  assign den_d = DEN_W'(pden[0]) + DEN_W'(pden[1]) + DEN_W'(pden[2]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        cross_dq[0][k] <= cross_f[k];
        a_dq[0][k]     <= a_f[k];
        for (int s = 1; s < MUL_LAT; s++) begin
          cross_dq[s][k] <= cross_dq[s-1][k];
          a_dq[s][k]     <= a_dq[s-1][k];
        end
        t_q[k]       <= T_W'(ptb[k]) - T_W'(ptc[k]);
        cross_s_q[k] <= cross_dq[MUL_LAT-1][k];
        a_s_q[k]     <= a_dq[MUL_LAT-1][k];
      end
      den_s_q <= den_d;
      deg_s_q <= den_d == '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      den_dq[0] <= den_s_q;
      deg_dq[0] <= deg_s_q;
      for (int s = 1; s < MUL_LAT; s++) begin
        den_dq[s] <= den_dq[s-1];
        deg_dq[s] <= deg_dq[s-1];
      end
      for (int k = 0; k < 3; k++) begin
        a2_dq[0][k] <= a_s_q[k];
        for (int s = 1; s < MUL_LAT; s++) begin
          a2_dq[s][k] <= a2_dq[s-1][k];
        end
        num_q[k] <= NUM_W'(pn1[k]) - NUM_W'(pn2[k]);
        a2_q[k]  <= a2_dq[MUL_LAT-1][k];
      end
      den2_q <= den_dq[MUL_LAT-1];
      deg2_q <= deg_dq[MUL_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      deg_oq[0] <= deg2_q;
      for (int s = 1; s < DIV_LAT; s++) begin
        deg_oq[s] <= deg_oq[s-1];
      end
    end
  end

  assign m_axis_tvalid = vld_q[PIPE_LAT-1];
  assign m_axis_tdata  = OUT_DATA_W'({center[2], center[1], center[0]});
  assign m_axis_tuser  = deg_oq[DIV_LAT-1];

endmodule

// File: rtl/core/tcc_mul.sv
// ----------------------------------------------------------------------------
// tcc_mul
// Five-stage signed multiplier built from registered 22x22 partial products.
// ----------------------------------------------------------------------------
module tcc_mul import tcc_pkg::*; (
  input  logic  clk_i,
  input  logic  en_i,
  input  mula_t a_i,
  input  mulb_t b_i,
  output mulp_t p_o
);

  localparam int AU_W = MUL_NA * MUL_K;
  localparam int BU_W = MUL_NB * MUL_K;
  localparam int PP_W = 2 * MUL_K;

  logic [AU_W-1:0]      ua_d, ua_q;
  logic [BU_W-1:0]      ub_d, ub_q;
  logic [3:0]           neg_q;
  logic [PP_W-1:0]      pp_q [MUL_NA][MUL_NB];
  logic [MUL_MAG_W-1:0] row_d [MUL_NA];
  logic [MUL_MAG_W-1:0] row_q [MUL_NA];
  logic [MUL_MAG_W-1:0] mag_d, mag_q;
  mulp_t                p_q;

  always_comb begin
    ua_d = a_i[MUL_A_W-1] ? AU_W'(AU_W'(~a_i) + AU_W'(1)) : AU_W'(a_i);
    ub_d = b_i[MUL_B_W-1] ? BU_W'(BU_W'(~b_i) + BU_W'(1)) : BU_W'(b_i);
  end

  always_comb begin
    for (int i = 0; i < MUL_NA; i++) begin
      row_d[i] = '0;
      for (int j = 0; j < MUL_NB; j++) begin
        row_d[i] = row_d[i] + (MUL_MAG_W'(pp_q[i][j]) << (j * MUL_K));
      end
    end
  end

  always_comb begin
    mag_d = '0;
    for (int i = 0; i < MUL_NA; i++) begin
      mag_d = mag_d + (row_q[i] << (i * MUL_K));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ua_q  <= ua_d;
      ub_q  <= ub_d;
      neg_q <= {neg_q[2:0], a_i[MUL_A_W-1] ^ b_i[MUL_B_W-1]};
      for (int i = 0; i < MUL_NA; i++) begin
        for (int j = 0; j < MUL_NB; j++) begin
          pp_q[i][j] <= PP_W'(ua_q[i*MUL_K +: MUL_K]) * PP_W'(ub_q[j*MUL_K +: MUL_K]);
        end
        row_q[i] <= row_d[i];
      end
      mag_q <= mag_d;
      p_q   <= neg_q[3] ? MUL_P_W'(-mag_q) : MUL_P_W'(mag_q);
    end
  end

  assign p_o = p_q;

endmodule

// File: rtl/core/tcc_front.sv
// ----------------------------------------------------------------------------
// tcc_front
// Edge vectors, squared edge lengths and cross product in three stages.
// ----------------------------------------------------------------------------
module tcc_front import tcc_pkg::*; (
  input  logic   clk_i,
  input  logic   en_i,
  input  crd_t   a_i     [3],
  input  crd_t   b_i     [3],
  input  crd_t   c_i     [3],
  output crd_t   a_o     [3],
  output diff_t  ba_o    [3],
  output diff_t  ca_o    [3],
  output len_t   bal_o,
  output len_t   cal_o,
  output cross_t cross_o [3]
);

  crd_t   a1_q [3], a2_q [3], a3_q [3];
  diff_t  ba1_q [3], ca1_q [3], ba2_q [3], ca2_q [3], ba3_q [3], ca3_q [3];
  sq_t    sb2_q [3], sc2_q [3], pc1_q [3], pc2_q [3];
  len_t   bal_q, cal_q;
  cross_t cross_q [3];

  for (genvar k = 0; k < 3; k++) begin : g_axis
    localparam int K1 = (k + 1) % 3;
    localparam int K2 = (k + 2) % 3;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        a1_q[k]    <= a_i[k];
        ba1_q[k]   <= DIFF_W'(b_i[k]) - DIFF_W'(a_i[k]);
        ca1_q[k]   <= DIFF_W'(c_i[k]) - DIFF_W'(a_i[k]);
        a2_q[k]    <= a1_q[k];
        ba2_q[k]   <= ba1_q[k];
        ca2_q[k]   <= ca1_q[k];
        sb2_q[k]   <= SQ_W'(ba1_q[k]) * SQ_W'(ba1_q[k]);
        sc2_q[k]   <= SQ_W'(ca1_q[k]) * SQ_W'(ca1_q[k]);
        pc1_q[k]   <= SQ_W'(ba1_q[K1]) * SQ_W'(ca1_q[K2]);
        pc2_q[k]   <= SQ_W'(ca1_q[K1]) * SQ_W'(ba1_q[K2]);
        a3_q[k]    <= a2_q[k];
        ba3_q[k]   <= ba2_q[k];
        ca3_q[k]   <= ca2_q[k];
        cross_q[k] <= CROSS_W'(pc1_q[k]) - CROSS_W'(pc2_q[k]);
      end
    end

    assign a_o[k]     = a3_q[k];
    assign ba_o[k]    = ba3_q[k];
    assign ca_o[k]    = ca3_q[k];
    assign cross_o[k] = cross_q[k];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bal_q <= LEN_W'(sb2_q[0]) + LEN_W'(sb2_q[1]) + LEN_W'(sb2_q[2]);
      cal_q <= LEN_W'(sc2_q[0]) + LEN_W'(sc2_q[1]) + LEN_W'(sc2_q[2]);
    end
  end

  assign bal_o = bal_q;
  assign cal_o = cal_q;

endmodule

// File: rtl/core/tcc_div.sv
// ----------------------------------------------------------------------------
// tcc_div
// Rounded pipelined division of one axis, one quotient bit per stage, with
// the vertex offset, saturation and degenerate selection at the end.
// ----------------------------------------------------------------------------
module tcc_div import tcc_pkg::*; (
  input  logic clk_i,
  input  logic en_i,
  input  num_t num_i,
  input  den_t den_i,
  input  crd_t base_i,
  input  logic deg_i,
  output out_t center_o
);

  logic [NUM_W-1:0]   mag1_q;
  den_t               den1_q;
  div_side_t          side1_q, side2_q;
  logic [NUMER_W-1:0] n2_q, hi;
  logic [DIVR_W-1:0]  dvs2_q;

  logic [DIVR_W-1:0]  rem_q  [QUO_W+1];
  logic [QUO_W-1:0]   low_q  [QUO_W+1];
  logic [QUO_W-1:0]   quo_q  [QUO_W+1];
  logic [DIVR_W-1:0]  dvs_q  [QUO_W+1];
  div_side_t          side_q [QUO_W+1];
  logic               ovf_q  [QUO_W+1];

  logic signed [OUT_W+1:0] off_s, base_s, sum_s;
  logic                    fits;
  out_t                    res_d, res_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag1_q <= num_i[NUM_W-1] ? NUM_W'(NUM_W'(~num_i) + NUM_W'(1)) : NUM_W'(num_i);
      den1_q <= den_i;
      side1_q <= '{neg: num_i[NUM_W-1], deg: deg_i, base: base_i};
      n2_q    <= (NUMER_W'(mag1_q) << FRAC_BITS) + NUMER_W'(den1_q);
      dvs2_q  <= {den1_q, 1'b0};
      side2_q <= side1_q;
    end
  end

  assign hi = n2_q >> QUO_W;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ovf_q[0]  <= hi >= NUMER_W'(dvs2_q);
      rem_q[0]  <= DIVR_W'(hi);
      low_q[0]  <= n2_q[QUO_W-1:0];
      quo_q[0]  <= '0;
      dvs_q[0]  <= dvs2_q;
      side_q[0] <= side2_q;
    end
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_step
    logic [DIVR_W:0] r2;
    logic            ge;

    assign r2 = {rem_q[k], low_q[k][QUO_W-1]};
    assign ge = r2 >= {1'b0, dvs_q[k]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1]  <= ge ? DIVR_W'(r2 - {1'b0, dvs_q[k]}) : DIVR_W'(r2);
        low_q[k+1]  <= low_q[k] << 1;
        quo_q[k+1]  <= {quo_q[k][QUO_W-2:0], ge};
        dvs_q[k+1]  <= dvs_q[k];
        side_q[k+1] <= side_q[k];
        ovf_q[k+1]  <= ovf_q[k];
      end
    end
  end

  always_comb begin
    off_s  = $signed({2'b00, quo_q[QUO_W]});
    if (side_q[QUO_W].neg) begin
      off_s = -off_s;
    end
    base_s = (OUT_W + 2)'($signed(side_q[QUO_W].base)) <<< FRAC_BITS;
    sum_s  = off_s + base_s;
    fits   = (sum_s[OUT_W+1:OUT_W-1] == '0) || (sum_s[OUT_W+1:OUT_W-1] == '1);
    if (side_q[QUO_W].deg) begin
      res_d = base_s[OUT_W-1:0];
    end else if (ovf_q[QUO_W]) begin
      res_d = side_q[QUO_W].neg ? OUT_MIN : OUT_MAX;
    end else if (!fits) begin
      res_d = sum_s[OUT_W+1] ? OUT_MIN : OUT_MAX;
    end else begin
      res_d = sum_s[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign center_o = res_q;

endmodule

// File: tb/triangle_circumcenter_3d_tb.sv
// ----------------------------------------------------------------------------
// triangle_circumcenter_3d_tb
// Self-checking testbench for the 3D triangle circumcenter pipeline.
// ----------------------------------------------------------------------------
// Requests carry three vertices; an independent predictor computes the
// circumcenter in wide signed integers, rounds half away from zero, adds
// vertex a and saturates to 48 bits, or flags a degenerate triangle. Each
// result is checked in order against the oldest predicted center. Both
// streams idle at random, with one long receiver hold-off to fill the pipe.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module triangle_circumcenter_3d_tb;
  import tcc_pkg::*;

  typedef struct packed {
    logic  deg;
    out_t  cz;
    out_t  cy;
    out_t  cx;
  } center_t;

  typedef logic signed [255:0] big_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;

  center_t centers_due[$];
  int      mismatches = 0;
  bit      src_steady = 1'b0;
  bit      snk_steady = 1'b0;
  int      snk_holdoff = 0;

  triangle_circumcenter_3d dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic out_t round_axis(big_t num, big_t den, big_t base);
    big_t mag;
    big_t sum;
    big_t lim_hi;
    big_t lim_lo;
    lim_hi = (big_t'(1) <<< (OUT_W - 1)) - 1;
    lim_lo = -(big_t'(1) <<< (OUT_W - 1));
    mag = (((num < 0) ? -num : num) <<< FRAC_BITS) + den;
    mag = mag / (2 * den);
    sum = ((num < 0) ? -mag : mag) + (base <<< FRAC_BITS);
    if (sum > lim_hi) return OUT_MAX;
    if (sum < lim_lo) return OUT_MIN;
    return out_t'(sum);
  endfunction

  function automatic center_t predict_center(crd_t v[9]);
    big_t a[3], ba[3], ca[3];
    big_t bl, cl, den, t[3], x[3];
    center_t r;
    for (int i = 0; i < 3; i++) begin
      a[i] = big_t'(v[i]);
      ba[i] = big_t'(v[3 + i]) - a[i];
      ca[i] = big_t'(v[6 + i]) - a[i];
    end
    bl = ba[0] * ba[0] + ba[1] * ba[1] + ba[2] * ba[2];
    cl = ca[0] * ca[0] + ca[1] * ca[1] + ca[2] * ca[2];
    x[0] = ba[1] * ca[2] - ca[1] * ba[2];
    x[1] = ba[2] * ca[0] - ca[2] * ba[0];
    x[2] = ba[0] * ca[1] - ca[0] * ba[1];
    den = x[0] * x[0] + x[1] * x[1] + x[2] * x[2];
    if (den == 0) begin
      r.deg = 1'b1;
      r.cx = out_t'(a[0] <<< FRAC_BITS);
      r.cy = out_t'(a[1] <<< FRAC_BITS);
      r.cz = out_t'(a[2] <<< FRAC_BITS);
      return r;
    end
    for (int i = 0; i < 3; i++) t[i] = bl * ca[i] - cl * ba[i];
    r.deg = 1'b0;
    r.cx = round_axis(t[1] * x[2] - t[2] * x[1], den, a[0]);
    r.cy = round_axis(t[2] * x[0] - t[0] * x[2], den, a[1]);
    r.cz = round_axis(t[0] * x[1] - t[1] * x[0], den, a[2]);
    return r;
  endfunction

  task automatic send_triangle(crd_t v[9]);
    logic [IN_DATA_W-1:0] d;
    d = '0;
    for (int i = 0; i < 9; i++) d[i*COORD_WIDTH +: COORD_WIDTH] = v[i];
    while (!src_steady && $urandom_range(99) < 9) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tdata <= d;
    s_axis_tvalid <= 1'b1;
    centers_due.push_back(predict_center(v));
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  function automatic crd_t rand_coord(int spread);
    case ($urandom_range(5))
      0: return crd_t'($urandom);
      1: return $urandom_range(1) ? {1'b0, {(COORD_WIDTH-1){1'b1}}} : {1'b1, {(COORD_WIDTH-1){1'b0}}};
      default: return crd_t'($signed($urandom_range(2 * spread)) - spread);
    endcase
  endfunction

  task automatic test_directed();
    crd_t v[9];
    crd_t hi, lo, lo1;
    hi = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    lo = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    lo1 = crd_t'(lo + 1);
    v = '{0, 0, 0, 4, 0, 0, 0, 4, 0}; send_triangle(v);
    v = '{0, 0, 0, 0, 0, 0, 0, 0, 0}; send_triangle(v);
    v = '{hi, hi, hi, hi, hi, hi, hi, hi, hi}; send_triangle(v);
    v = '{lo, lo, lo, lo, lo, lo, lo, lo, lo}; send_triangle(v);
    v = '{1, 2, 3, 2, 4, 6, 3, 6, 9}; send_triangle(v);
    v = '{lo, lo, lo, hi, lo, lo, lo, hi, lo}; send_triangle(v);
    v = '{hi, hi, hi, lo, hi, hi, hi, lo, hi}; send_triangle(v);
    v = '{lo, 0, hi, hi, lo, 0, 0, hi, lo}; send_triangle(v);
    v = '{0, 0, 0, 1, 0, 0, 0, 1, 0}; send_triangle(v);
    v = '{0, 0, 0, 3, 0, 0, 0, 1, 0}; send_triangle(v);
    v = '{-5, -5, -5, -4, -5, -5, -5, -5, -4}; send_triangle(v);
    v = '{0, 0, 0, 1, 1, 0, 2, 2, 1}; send_triangle(v);
    v = '{0, 0, 0, 2, 0, 0, 1, 0, 0}; send_triangle(v);
    v = '{hi, lo, hi, lo, hi, lo, hi, hi, lo}; send_triangle(v);
    v = '{lo, lo, lo, lo, lo, lo1, lo, lo1, lo}; send_triangle(v);
    v = '{-1, -1, -1, 0, 0, 0, 1, 1, 1}; send_triangle(v);
  endtask

  task automatic test_random(int count);
    crd_t v[9];
    int spread;
    for (int n = 0; n < count; n++) begin
      spread = (1 << $urandom_range(COORD_WIDTH - 1, 1)) - 1;
      foreach (v[i]) v[i] = rand_coord(spread);
      if ($urandom_range(19) == 0) begin
        for (int i = 0; i < 3; i++) v[6 + i] = v[3 + i];
      end
      src_steady = (n >= count / 2) && (n < count / 2 + 150);
      snk_steady = src_steady;
      send_triangle(v);
    end
    src_steady = 1'b0;
    snk_steady = 1'b0;
  endtask

  task automatic test_backpressure();
    crd_t v[9];
    snk_holdoff = 3 * PIPE_LAT;
    for (int n = 0; n < 2 * PIPE_LAT; n++) begin
      foreach (v[i]) v[i] = rand_coord(1000);
      send_triangle(v);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random(550);
    test_backpressure();
    test_random(550);
    s_axis_tvalid <= 1'b0;
    while (centers_due.size() != 0) @(posedge clk_i);
    repeat (PIPE_LAT + 10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  always @(negedge clk_i) begin
    if (snk_holdoff > 0) begin
      snk_holdoff <= snk_holdoff - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= rst_ni && (snk_steady || $urandom_range(99) >= 9);
    end
  end

  always @(posedge clk_i) begin
    center_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tuser, m_axis_tdata[3*OUT_W-1:0]};
      if (centers_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %h", got);
      end else begin
        want = centers_due.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch x exp %h got %h, y exp %h got %h", want.cx, got.cx,
                     want.cy, got.cy);
            $display("  z exp %h got %h, degenerate exp %b got %b", want.cz, got.cz,
                     want.deg, got.deg);
          end
        end
      end
    end
  end

  initial begin
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
